// File: rtl/wsp_pkg.sv
// Types and constants shared by the WAV stream parser modules.
package wsp_pkg;

   typedef enum logic [2:0] {
      PH_HEADER = 3'd0,
      PH_SCAN   = 3'd1,
      PH_SIZE   = 3'd2,
      PH_DATA   = 3'd3,
      PH_DONE   = 3'd4
   } phase_type;

   localparam logic        KIND_HEADER = 1'b0;
   localparam logic        KIND_SAMPLE = 1'b1;

   localparam logic [31:0] DATA_TAG    = 32'h64617461;

   // Byte offsets of the captured fields within the fixed header.
   localparam logic [5:0]  HDR_FORMAT  = 6'd20;
   localparam logic [5:0]  HDR_CHANS   = 6'd22;
   localparam logic [5:0]  HDR_RATE    = 6'd24;
   localparam logic [5:0]  HDR_BPS     = 6'd28;
   localparam logic [5:0]  HDR_ALIGN   = 6'd32;
   localparam logic [5:0]  HDR_BITS    = 6'd34;
   localparam logic [5:0]  HDR_LAST    = 6'd35;

   localparam logic [1:0]  GROUP_LAST  = 2'd3;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       start_of_file;
   } wsp_request_type;

   typedef struct packed {
      logic            valid;
      wsp_request_type req;
   } wsp_staged_type;

   typedef struct packed {
      logic               kind;
      logic [15:0]        audio_format;
      logic [15:0]        num_channels;
      logic [31:0]        sample_rate;
      logic [31:0]        byte_rate;
      logic [15:0]        block_align;
      logic [15:0]        bits_per_sample;
      logic [31:0]        data_size;
      logic signed [15:0] sample_value;
      logic [15:0]        channel_index;
      logic               last_sample;
   } wsp_result_type;

endpackage

// File: rtl/wsp_req_if.sv
// Request channel carrying one file byte per transfer.
interface wsp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       start_of_file;

   modport source (output valid, output data_byte, output start_of_file, input ready);
   modport sink   (input valid, input data_byte, input start_of_file, output ready);
endinterface

// File: rtl/wsp_rsp_if.sv
// Result channel carrying header summaries and audio samples.
interface wsp_rsp_if;
   logic               valid;
   logic               ready;
   logic               kind;
   logic [15:0]        audio_format;
   logic [15:0]        num_channels;
   logic [31:0]        sample_rate;
   logic [31:0]        byte_rate;
   logic [15:0]        block_align;
   logic [15:0]        bits_per_sample;
   logic [31:0]        data_size;
   logic signed [15:0] sample_value;
   logic [15:0]        channel_index;
   logic               last_sample;

   modport source (output valid, output kind, output audio_format, output num_channels,
                   output sample_rate, output byte_rate, output block_align,
                   output bits_per_sample, output data_size, output sample_value,
                   output channel_index, output last_sample, input ready);
   modport sink   (input valid, input kind, input audio_format, input num_channels,
                   input sample_rate, input byte_rate, input block_align,
                   input bits_per_sample, input data_size, input sample_value,
                   input channel_index, input last_sample, output ready);
endinterface

// File: rtl/wav_stream_parser_unit.sv
// Top level of the byte-serial WAV (RIFF PCM 16-bit) stream parser.
//
// The request channel takes one file byte per request, in file order, with
// start_of_file marking byte 0 of a new file; the mark restarts the parse in
// any phase and drops a half-built sample. The 36-byte header is captured,
// 4-byte groups are scanned for the "data" tag, and after the 4-byte size one
// header summary goes out on the result channel (kind 0). Each following pair
// of bytes then gives one sample result (kind 1) with its channel position
// and a flag on the final sample. Odd trailing bytes and bytes after the data
// chunk give no result.
// Path: a request passes through the input register, then the parse logic
// into the result register, which presents the result.
// Throughput: one request per clock cycle while the receiver takes results;
// the parse state steps once per request, so the only limit is the result register.
// While the receiver stalls, one request waits in the input register and then
// the request channel deasserts ready; nothing is lost or repeated.
// Reset clears the parse state to the start of the header, as if a file began.
module wav_stream_parser_unit (
   input  logic      clock,
   input  logic      reset,
   wsp_req_if.sink   req_chan,
   wsp_rsp_if.source rsp_chan
);
   import wsp_pkg::*;

   wsp_staged_type staged;
   wsp_result_type result;
   logic           result_valid;
   logic           advance;
   logic           step;

   assign step = staged.valid && advance;

   wsp_input_stage u_input (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .advance  (advance),
      .staged   (staged)
   );

   wsp_parse_core u_core (
      .clock        (clock),
      .reset        (reset),
      .step         (step),
      .req          (staged.req),
      .result_valid (result_valid),
      .result       (result)
   );

   wsp_output_stage u_output (
      .clock        (clock),
      .reset        (reset),
      .result_valid (result_valid),
      .result       (result),
      .advance      (advance),
      .rsp_chan     (rsp_chan)
   );

   // A sample never carries a channel position beyond the channel count.
   a_channel_in_range: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && (rsp_chan.kind == KIND_SAMPLE) && (rsp_chan.num_channels != 16'd0))
      |-> (rsp_chan.channel_index < rsp_chan.num_channels))
      else $error("sample channel position out of range");

   // The header summary carries no sample content.
   a_header_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && (rsp_chan.kind == KIND_HEADER))
      |-> ((rsp_chan.sample_value == 16'sd0) && (rsp_chan.channel_index == 16'd0)
           && !rsp_chan.last_sample))
      else $error("header summary carries sample fields");

   // A request waiting in the input register is held until the parser takes it.
   a_staged_hold: assert property (@(posedge clock) disable iff (reset)
      (staged.valid && !advance) |=> (staged.valid && $stable(staged.req)))
      else $error("staged request lost while stalled");

   // No result is produced without a request in the input register.
   a_result_source: assert property (@(posedge clock) disable iff (reset)
      result_valid |-> (staged.valid && advance))
      else $error("result without a staged request");
endmodule

// File: rtl/wsp_input_stage.sv
// Input register that holds one accepted request until the parser takes it.
module wsp_input_stage (
   input  logic                    clock,
   input  logic                    reset,
   wsp_req_if.sink                 req_chan,
   input  logic                    advance,
   output wsp_pkg::wsp_staged_type staged
);
   import wsp_pkg::*;

   logic            valid_ff;
   logic            valid_in;
   wsp_request_type req_ff;
   logic            take;

   assign req_chan.ready = !valid_ff || advance;
   assign take           = req_chan.valid && req_chan.ready;
   assign valid_in       = req_chan.ready ? req_chan.valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         req_ff.data_byte     <= req_chan.data_byte;
         req_ff.start_of_file <= req_chan.start_of_file;
      end
   end

   assign staged.valid = valid_ff;
   assign staged.req   = req_ff;
endmodule

// File: rtl/wsp_parse_core.sv
// Parse state machine: header capture, tag scan, size capture and sample assembly.
module wsp_parse_core (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     step,
   input  wsp_pkg::wsp_request_type req,
   output logic                     result_valid,
   output wsp_pkg::wsp_result_type  result
);
   import wsp_pkg::*;

   phase_type   phase_ff,  phase_in;
   logic [5:0]  hdr_cnt_ff, hdr_cnt_in;
   logic [1:0]  grp_cnt_ff, grp_cnt_in;
   logic [31:0] tag_ff,    tag_in;
   logic [15:0] format_ff, format_in;
   logic [15:0] chans_ff,  chans_in;
   logic [31:0] rate_ff,   rate_in;
   logic [31:0] bps_ff,    bps_in;
   logic [15:0] align_ff,  align_in;
   logic [15:0] bits_ff,   bits_in;
   logic [31:0] size_ff,   size_in;
   logic [30:0] left_ff,   left_in;
   logic [7:0]  low_ff,    low_in;
   logic        bphase_ff, bphase_in;
   logic [15:0] chan_ff,   chan_in;

   // View of the control state after an optional restart by the start mark.
   phase_type   ph;
   logic [5:0]  hdr_cnt;
   logic [1:0]  grp_cnt;
   logic [31:0] tag;
   logic [30:0] left;
   logic        bphase;
   logic [15:0] chan;
   logic [15:0] chan_mod;
   logic [16:0] chan_next;
   logic [7:0]  b;
   logic        produce;

   always_comb begin
      b        = req.data_byte;
      ph       = req.start_of_file ? PH_HEADER : phase_ff;
      hdr_cnt  = req.start_of_file ? 6'd0  : hdr_cnt_ff;
      grp_cnt  = req.start_of_file ? 2'd0  : grp_cnt_ff;
      tag      = req.start_of_file ? 32'd0 : tag_ff;
      left     = req.start_of_file ? 31'd0 : left_ff;
      bphase   = req.start_of_file ? 1'b0  : bphase_ff;
      chan     = req.start_of_file ? 16'd0 : chan_ff;
      chan_mod = (chans_ff == 16'd0) ? 16'd1 : chans_ff;
      chan_next = {1'b0, chan} + 17'd1;

      phase_in   = ph;
      hdr_cnt_in = hdr_cnt;
      grp_cnt_in = grp_cnt;
      tag_in     = tag;
      format_in  = format_ff;
      chans_in   = chans_ff;
      rate_in    = rate_ff;
      bps_in     = bps_ff;
      align_in   = align_ff;
      bits_in    = bits_ff;
      size_in    = size_ff;
      left_in    = left;
      low_in     = req.start_of_file ? 8'd0 : low_ff;
      bphase_in  = bphase;
      chan_in    = chan;
      produce    = 1'b0;

      result.kind          = KIND_HEADER;
      result.sample_value  = 16'sd0;
      result.channel_index = 16'd0;
      result.last_sample   = 1'b0;

      case (ph)
         PH_HEADER: begin
            case (hdr_cnt)
               HDR_FORMAT:         format_in[7:0]   = b;
               HDR_FORMAT + 6'd1:  format_in[15:8]  = b;
               HDR_CHANS:          chans_in[7:0]    = b;
               HDR_CHANS + 6'd1:   chans_in[15:8]   = b;
               HDR_RATE:           rate_in[7:0]     = b;
               HDR_RATE + 6'd1:    rate_in[15:8]    = b;
               HDR_RATE + 6'd2:    rate_in[23:16]   = b;
               HDR_RATE + 6'd3:    rate_in[31:24]   = b;
               HDR_BPS:            bps_in[7:0]      = b;
               HDR_BPS + 6'd1:     bps_in[15:8]     = b;
               HDR_BPS + 6'd2:     bps_in[23:16]    = b;
               HDR_BPS + 6'd3:     bps_in[31:24]    = b;
               HDR_ALIGN:          align_in[7:0]    = b;
               HDR_ALIGN + 6'd1:   align_in[15:8]   = b;
               HDR_BITS:           bits_in[7:0]     = b;
               HDR_BITS + 6'd1:    bits_in[15:8]    = b;
               default: ;
            endcase
            if (hdr_cnt >= HDR_LAST) begin
               hdr_cnt_in = 6'd0;
               grp_cnt_in = 2'd0;
               phase_in   = PH_SCAN;
            end else begin
               hdr_cnt_in = hdr_cnt + 6'd1;
            end
         end
         PH_SCAN: begin
            tag_in = {tag[23:0], b};
            if (grp_cnt == GROUP_LAST) begin
               grp_cnt_in = 2'd0;
               if (tag_in == DATA_TAG) begin
                  phase_in = PH_SIZE;
               end
            end else begin
               grp_cnt_in = grp_cnt + 2'd1;
            end
         end
         PH_SIZE: begin
            case (grp_cnt)
               2'd0:    size_in[7:0]   = b;
               2'd1:    size_in[15:8]  = b;
               2'd2:    size_in[23:16] = b;
               default: size_in[31:24] = b;
            endcase
            if (grp_cnt != GROUP_LAST) begin
               grp_cnt_in = grp_cnt + 2'd1;
            end else begin
               grp_cnt_in = 2'd0;
               left_in    = size_in[31:1];
               bphase_in  = 1'b0;
               chan_in    = 16'd0;
               phase_in   = (size_in[31:1] != 31'd0) ? PH_DATA : PH_DONE;
               produce    = 1'b1;
            end
         end
         PH_DATA: begin
            if (!bphase) begin
               low_in    = b;
               bphase_in = 1'b1;
            end else begin
               bphase_in            = 1'b0;
               produce              = 1'b1;
               result.kind          = KIND_SAMPLE;
               result.sample_value  = {b, low_ff};
               result.channel_index = chan;
               result.last_sample   = (left == 31'd1);
               chan_in  = (chan_next >= {1'b0, chan_mod}) ? 16'd0 : chan_next[15:0];
               left_in  = left - 31'd1;
               if (left_in == 31'd0) begin
                  phase_in = PH_DONE;
               end
            end
         end
         default: ;
      endcase

      result.audio_format    = format_in;
      result.num_channels    = chans_in;
      result.sample_rate     = rate_in;
      result.byte_rate       = bps_in;
      result.block_align     = align_in;
      result.bits_per_sample = bits_in;
      result.data_size       = size_in;
      result_valid           = step && produce;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_HEADER;
         hdr_cnt_ff <= 6'd0;
         grp_cnt_ff <= 2'd0;
         tag_ff     <= 32'd0;
         format_ff  <= 16'd0;
         chans_ff   <= 16'd0;
         rate_ff    <= 32'd0;
         bps_ff     <= 32'd0;
         align_ff   <= 16'd0;
         bits_ff    <= 16'd0;
         size_ff    <= 32'd0;
         left_ff    <= 31'd0;
         low_ff     <= 8'd0;
         bphase_ff  <= 1'b0;
         chan_ff    <= 16'd0;
      end else if (step) begin
         phase_ff   <= phase_in;
         hdr_cnt_ff <= hdr_cnt_in;
         grp_cnt_ff <= grp_cnt_in;
         tag_ff     <= tag_in;
         format_ff  <= format_in;
         chans_ff   <= chans_in;
         rate_ff    <= rate_in;
         bps_ff     <= bps_in;
         align_ff   <= align_in;
         bits_ff    <= bits_in;
         size_ff    <= size_in;
         left_ff    <= left_in;
         low_ff     <= low_in;
         bphase_ff  <= bphase_in;
         chan_ff    <= chan_in;
      end
   end
endmodule

// File: rtl/wsp_output_stage.sv
// Result register that drives the result channel and paces the pipeline.
module wsp_output_stage (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    result_valid,
   input  wsp_pkg::wsp_result_type result,
   output logic                    advance,
   wsp_rsp_if.source               rsp_chan
);
   import wsp_pkg::*;

   logic           valid_ff;
   logic           valid_in;
   wsp_result_type out_ff;

   // The pipeline moves whenever the result register is empty or being emptied.
   assign advance  = !valid_ff || rsp_chan.ready;
   assign valid_in = advance ? result_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && result_valid) begin
         out_ff <= result;
      end
   end

   assign rsp_chan.valid           = valid_ff;
   assign rsp_chan.kind            = out_ff.kind;
   assign rsp_chan.audio_format    = out_ff.audio_format;
   assign rsp_chan.num_channels    = out_ff.num_channels;
   assign rsp_chan.sample_rate     = out_ff.sample_rate;
   assign rsp_chan.byte_rate       = out_ff.byte_rate;
   assign rsp_chan.block_align     = out_ff.block_align;
   assign rsp_chan.bits_per_sample = out_ff.bits_per_sample;
   assign rsp_chan.data_size       = out_ff.data_size;
   assign rsp_chan.sample_value    = out_ff.sample_value;
   assign rsp_chan.channel_index   = out_ff.channel_index;
   assign rsp_chan.last_sample     = out_ff.last_sample;
endmodule

// File: tb/sv/wav_parse_monitor.sv
// Monitor that predicts the WAV parser's results from accepted requests and checks them.
module wav_parse_monitor
   import wsp_pkg::*;
(
   input  logic clock,
   input  logic reset,
   wsp_req_if   req_seen,
   wsp_rsp_if   rsp_seen,
   output int   mismatch_total,
   output int   results_owed,
   output int   headers_checked,
   output int   samples_checked
);
   timeunit 1ns;
   timeprecision 1ps;

   // Parse state, kept independently of the block.
   phase_type   phase;
   logic [5:0]  hdr_pos;
   logic [1:0]  group_pos;
   logic [31:0] tag_window;
   logic [15:0] fmt_code;
   logic [15:0] chan_total;
   logic [31:0] rate_hz;
   logic [31:0] rate_bytes;
   logic [15:0] frame_align;
   logic [15:0] sample_width;
   logic [31:0] chunk_len;
   logic [30:0] samples_owed;
   logic [7:0]  low_byte;
   logic        high_due;
   logic [15:0] chan_pos;

   wsp_result_type expected_q[$];
   int failures;
   int headers;
   int samples;

   function automatic void restart_parse();
      phase        = PH_HEADER;
      hdr_pos      = '0;
      group_pos    = '0;
      tag_window   = '0;
      samples_owed = '0;
      low_byte     = '0;
      high_due     = 1'b0;
      chan_pos     = '0;
   endfunction

   function automatic wsp_result_type header_fields(input logic kind);
      wsp_result_type r;
      r                 = '0;
      r.kind            = kind;
      r.audio_format    = fmt_code;
      r.num_channels    = chan_total;
      r.sample_rate     = rate_hz;
      r.byte_rate       = rate_bytes;
      r.block_align     = frame_align;
      r.bits_per_sample = sample_width;
      r.data_size       = chunk_len;
      return r;
   endfunction

   // Advances the parse by one byte; returns 1 when the byte completes a result.
   function automatic logic parse_byte(input logic [7:0] value, input logic mark,
                                       output wsp_result_type res);
      logic        produced;
      logic [16:0] next_pos;
      logic [16:0] wrap;
      produced = 1'b0;
      res      = '0;
      if (mark) begin
         restart_parse();
      end
      case (phase)
         PH_HEADER: begin
            if (hdr_pos >= HDR_BITS) begin
               sample_width[8*(hdr_pos - HDR_BITS) +: 8] = value;
            end else if (hdr_pos >= HDR_ALIGN) begin
               frame_align[8*(hdr_pos - HDR_ALIGN) +: 8] = value;
            end else if (hdr_pos >= HDR_BPS) begin
               rate_bytes[8*(hdr_pos - HDR_BPS) +: 8] = value;
            end else if (hdr_pos >= HDR_RATE) begin
               rate_hz[8*(hdr_pos - HDR_RATE) +: 8] = value;
            end else if (hdr_pos >= HDR_CHANS) begin
               chan_total[8*(hdr_pos - HDR_CHANS) +: 8] = value;
            end else if (hdr_pos >= HDR_FORMAT) begin
               fmt_code[8*(hdr_pos - HDR_FORMAT) +: 8] = value;
            end
            if (hdr_pos == HDR_LAST) begin
               hdr_pos   = '0;
               group_pos = '0;
               phase     = PH_SCAN;
            end else begin
               hdr_pos = hdr_pos + 6'd1;
            end
         end
         PH_SCAN: begin
            // The tag is only recognised on an aligned group boundary.
            tag_window = {tag_window[23:0], value};
            if (group_pos == GROUP_LAST) begin
               group_pos = '0;
               if (tag_window == DATA_TAG) begin
                  phase = PH_SIZE;
               end
            end else begin
               group_pos = group_pos + 2'd1;
            end
         end
         PH_SIZE: begin
            chunk_len[8*group_pos +: 8] = value;
            if (group_pos != GROUP_LAST) begin
               group_pos = group_pos + 2'd1;
            end else begin
               group_pos    = '0;
               samples_owed = chunk_len[31:1];
               high_due     = 1'b0;
               chan_pos     = '0;
               phase        = (samples_owed != '0) ? PH_DATA : PH_DONE;
               res          = header_fields(KIND_HEADER);
               produced     = 1'b1;
            end
         end
         PH_DATA: begin
            if (!high_due) begin
               low_byte = value;
               high_due = 1'b1;
            end else begin
               high_due          = 1'b0;
               res               = header_fields(KIND_SAMPLE);
               res.sample_value  = {value, low_byte};
               res.channel_index = chan_pos;
               res.last_sample   = (samples_owed == 31'd1);
               // A channel count of zero behaves as a single channel.
               next_pos = {1'b0, chan_pos} + 17'd1;
               wrap     = (chan_total == '0) ? 17'd1 : {1'b0, chan_total};
               chan_pos = (next_pos >= wrap) ? '0 : next_pos[15:0];
               samples_owed = samples_owed - 31'd1;
               if (samples_owed == '0) begin
                  phase = PH_DONE;
               end
               produced = 1'b1;
            end
         end
         default: begin
         end
      endcase
      return produced;
   endfunction

   function automatic string describe(input wsp_result_type r);
      return $sformatf({"kind %0d fmt %h ch %h rate %h bps %h align %h bits %h",
                        " size %h sample %h idx %h last %0d"},
                       r.kind, r.audio_format, r.num_channels, r.sample_rate,
                       r.byte_rate, r.block_align, r.bits_per_sample, r.data_size,
                       r.sample_value, r.channel_index, r.last_sample);
   endfunction

   function automatic void note_failure(input string msg);
      failures++;
      if (failures <= 10) begin
         $display("[%0t] %s", $time, msg);
      end
   endfunction

   always @(posedge clock) begin : track
      wsp_result_type predicted;
      wsp_result_type observed;
      wsp_result_type oldest;
      if (reset) begin
         restart_parse();
         fmt_code     = '0;
         chan_total   = '0;
         rate_hz      = '0;
         rate_bytes   = '0;
         frame_align  = '0;
         sample_width = '0;
         chunk_len    = '0;
         expected_q.delete();
         failures = 0;
         headers  = 0;
         samples  = 0;
      end else begin
         if (rsp_seen.valid && rsp_seen.ready) begin
            observed.kind            = rsp_seen.kind;
            observed.audio_format    = rsp_seen.audio_format;
            observed.num_channels    = rsp_seen.num_channels;
            observed.sample_rate     = rsp_seen.sample_rate;
            observed.byte_rate       = rsp_seen.byte_rate;
            observed.block_align     = rsp_seen.block_align;
            observed.bits_per_sample = rsp_seen.bits_per_sample;
            observed.data_size       = rsp_seen.data_size;
            observed.sample_value    = rsp_seen.sample_value;
            observed.channel_index   = rsp_seen.channel_index;
            observed.last_sample     = rsp_seen.last_sample;
            if (observed.kind == KIND_HEADER) begin
               headers++;
            end else begin
               samples++;
            end
            if (expected_q.size() == 0) begin
               note_failure({"result with nothing expected: ", describe(observed)});
            end else begin
               oldest = expected_q.pop_front();
               if (observed !== oldest) begin
                  note_failure({"result mismatch\n   expected ", describe(oldest),
                                "\n   actual   ", describe(observed)});
               end
            end
         end
         if (req_seen.valid && req_seen.ready) begin
            if (parse_byte(req_seen.data_byte, req_seen.start_of_file, predicted)) begin
               expected_q = {expected_q, predicted};
            end
         end
      end
      mismatch_total  <= failures;
      results_owed    <= expected_q.size();
      headers_checked <= headers;
      samples_checked <= samples;
   end

endmodule

// File: tb/sv/testbench.sv
// Top of the WAV stream parser testbench: clock, reset, request stimulus and verdict.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import wsp_pkg::*;

   typedef enum logic [1:0] {
      RX_STREAM,
      RX_COIN,
      RX_PERIODIC,
      RX_SPARSE
   } rx_pattern_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   wsp_req_if req_chan ();
   wsp_rsp_if rsp_chan ();

   int mismatch_total;
   int results_owed;
   int headers_checked;
   int samples_checked;

   int bytes_sent = 0;
   int files_sent = 0;
   int burst_left = 0;
   logic [7:0] file_image[$];

   wav_stream_parser_unit dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   wav_parse_monitor parse_monitor (
      .clock           (clock),
      .reset           (reset),
      .req_seen        (req_chan),
      .rsp_seen        (rsp_chan),
      .mismatch_total  (mismatch_total),
      .results_owed    (results_owed),
      .headers_checked (headers_checked),
      .samples_checked (samples_checked)
   );

   always begin
      #6ns clock = 1'b1;
      #6ns clock = 1'b0;
   end

   initial begin : watchdog
      #2ms;
      $display("FAILED: results differ");
      $finish;
   end

   // Offers one request and returns at the edge where it is taken; gaps fall between bursts.
   task automatic send_byte(input logic [7:0] value, input logic mark);
      int gap;
      if (burst_left == 0) begin
         gap        = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
         burst_left = $urandom_range(1, 48);
         if (gap > 0) begin
            req_chan.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_chan.valid         <= 1'b1;
      req_chan.data_byte     <= value;
      req_chan.start_of_file <= mark;
      do @(posedge clock); while (!req_chan.ready);
      bytes_sent++;
   endtask

   task automatic wait_drained();
      req_chan.valid <= 1'b0;
      burst_left = 0;
      do @(posedge clock); while (results_owed != 0);
   endtask

   function automatic void push_le(input logic [31:0] value, input int count);
      for (int i = 0; i < count; i++) begin
         file_image = {file_image, value[8*i +: 8]};
      end
   endfunction

   function automatic void build_file(input logic [15:0] chans, input int junk_groups,
                                      input logic [31:0] size, input int data_len);
      file_image.delete();
      repeat (HDR_FORMAT) file_image = {file_image, 8'($urandom)};
      push_le($urandom, 2);
      push_le({16'h0, chans}, 2);
      push_le($urandom, 4);
      push_le($urandom, 4);
      push_le($urandom, 2);
      push_le($urandom, 2);
      repeat (4 * junk_groups) file_image = {file_image, 8'($urandom)};
      for (int i = 3; i >= 0; i--) begin
         file_image = {file_image, DATA_TAG[8*i +: 8]};
      end
      push_le(size, 4);
      repeat (data_len) file_image = {file_image, 8'($urandom)};
   endfunction

   function automatic void keep_first(input int count);
      while (file_image.size() > count) begin
         void'(file_image.pop_back());
      end
   endfunction

   task automatic send_file(input logic mark);
      foreach (file_image[i]) begin
         send_byte(file_image[i], (i == 0) ? mark : 1'b0);
      end
      files_sent++;
   endtask

   initial begin : receiver_stalls
      rx_pattern_type pattern;
      int span;
      rsp_chan.ready <= 1'b0;
      forever begin
         pattern = rx_pattern_type'($urandom_range(0, 3));
         span    = $urandom_range(8, 90);
         for (int tick = 0; tick < span; tick++) begin
            @(posedge clock);
            case (pattern)
               RX_STREAM:   rsp_chan.ready <= 1'b1;
               RX_COIN:     rsp_chan.ready <= 1'($urandom_range(0, 1));
               RX_PERIODIC: rsp_chan.ready <= ((tick % 5) < 2);
               default:     rsp_chan.ready <= ($urandom_range(0, 11) == 0);
            endcase
         end
      end
   end

   initial begin : stimulus
      logic [7:0]  sample_edges[$];
      int          roll;
      logic [15:0] chans;
      logic [31:0] size;
      int          data_len;
      sample_edges = '{8'h00, 8'h80, 8'hFF, 8'h7F, 8'h00, 8'h00, 8'hFF, 8'hFF,
                       8'hAA, 8'h55};
      req_chan.valid         <= 1'b0;
      req_chan.data_byte     <= '0;
      req_chan.start_of_file <= 1'b0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // First file arrives without a start mark, header fields at all ones,
      // extreme samples on two channels, then two bytes past the data.
      build_file(16'd2, 1, 32'd8, 0);
      for (int i = HDR_FORMAT; i <= HDR_LAST; i++) begin
         if (i < HDR_CHANS || i >= HDR_RATE) begin
            file_image[i] = 8'hFF;
         end
      end
      foreach (sample_edges[i]) begin
         file_image = {file_image, sample_edges[i]};
      end
      send_file(1'b0);

      // Zero channel count and zero header fields, odd data length plus a stray byte.
      build_file(16'd0, 0, 32'd5, 6);
      for (int i = HDR_FORMAT; i <= HDR_LAST; i++) begin
         file_image[i] = 8'h00;
      end
      send_file(1'b1);

      // Empty data chunks of sizes one and zero, with bytes after them.
      build_file(16'd1, 2, 32'd1, 3);
      send_file(1'b1);
      build_file(16'd4, 0, 32'd0, 2);
      send_file(1'b1);

      // Restarts in the middle of a sample, the header, the scan and the size.
      build_file(16'd3, 0, 32'd100, 3);
      send_file(1'b1);
      build_file(16'd5, 0, 32'd0, 0);
      keep_first(10);
      send_file(1'b1);
      build_file(16'd2, 3, 32'd0, 0);
      keep_first(40);
      send_file(1'b1);
      build_file(16'd1, 0, 32'd8, 0);
      keep_first(42);
      send_file(1'b1);
      build_file(16'hFFFF, 0, 32'd6, 6);
      send_file(1'b1);
      wait_drained();

      while (bytes_sent < 1400) begin
         roll  = $urandom_range(0, 9);
         chans = ($urandom_range(0, 4) == 0) ? 16'($urandom) : 16'($urandom_range(0, 6));
         if ($urandom_range(0, 5) == 0) begin
            size     = $urandom;
            data_len = $urandom_range(0, 40);
         end else begin
            size     = $urandom_range(0, 48);
            data_len = size + $urandom_range(0, 3);
         end
         if (roll == 0) begin
            // Noise: loose bytes with the occasional stray start mark.
            repeat ($urandom_range(1, 24)) begin
               send_byte(8'($urandom), ($urandom_range(0, 7) == 0));
            end
         end else begin
            build_file(chans, $urandom_range(0, 3), size, data_len);
            if (roll == 1) begin
               keep_first($urandom_range(1, file_image.size()));
            end
            send_file($urandom_range(0, 15) != 0);
         end
         if (files_sent == 20) begin
            wait_drained();
         end
      end

      wait_drained();
      repeat (16) @(posedge clock);
      $display("Run covered %0d requests in %0d files, including restarts, noise and cut files.",
               bytes_sent, files_sent);
      $display("Checked %0d header and %0d sample results; %0d failures.",
               headers_checked, samples_checked, mismatch_total);
      if (mismatch_total == 0 && results_owed == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule
